// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Types and constants shared by the MD5 message digest modules.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Initial chaining values.
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    // One classified item passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } t_item;

    // Back part states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Per-round additive constants.
    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    // Left rotate amount for a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
                4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;
                4'd14: s = 5'd15;  default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word index for a round.
    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] g;
        logic [3:0] n;
        begin
            n = r[3:0];
            case (r[5:4])
                2'd0:    g = n;
                2'd1:    g = 4'((n << 2) + n + 4'd1);
                2'd2:    g = 4'((n << 1) + n + 4'd5);
                default: g = 4'((n << 3) - n);
            endcase
            return g;
        end
    endfunction

endpackage

// ===== sv/md5_front.sv =====
// ----------------------------------------------------------------------------
// MD5 front part
// Accepts input items, drops items with neither flag, and queues the rest.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_message,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_item_take
);

    t_item              r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push_ok, pop_ok;

    // An item with neither flag set does nothing and is not queued.
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push_ok = i_push && !o_full && (i_byte_present || i_end_of_message);
    assign pop_ok  = i_item_take && (r_count != '0);

    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_queue[r_wr_ptr] <= '{data: i_data_byte, has_byte: i_byte_present,
                                   is_end: i_end_of_message};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop_ok)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (QUEUE_AW+1)'(push_ok) - (QUEUE_AW+1)'(pop_ok);
        end
    end

endmodule

// ===== sv/md5_back.sv =====
// ----------------------------------------------------------------------------
// MD5 back part
// Stores bytes in the block buffer, runs one compression round per cycle,
// pads the final block and presents the digest words.
// ----------------------------------------------------------------------------
module md5_back import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_item_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_number,
    output logic        o_last_word
);

    // Block buffer as sixteen words; a byte write updates one lane.
    logic [31:0] r_block [16];
    logic [31:0] r_ca, r_cb, r_cc, r_cd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [60:0] r_count;
    logic [5:0]  r_round;
    logic [5:0]  r_pad_pos;
    logic        r_final;
    logic        r_pad_twice;
    logic        r_mark;
    logic [1:0]  r_word;
    t_state      r_state, n_state;

    logic        take_byte_now;
    logic [5:0]  pos;
    logic [5:0]  pad_start;
    logic [31:0] f, sum, rot, w_g;
    logic [4:0]  sh;
    logic [63:0] bits;
    logic [7:0]  pad_val;

    // Items are taken only while idle.
    assign o_item_take   = (r_state == ST_IDLE) && i_item_valid;
    assign take_byte_now = o_item_take && i_item.has_byte;
    assign pos           = r_count[5:0];
    assign bits          = {r_count, 3'b000};
    // The pad marker goes right after the last message byte.
    assign pad_start     = pos + {5'd0, i_item.has_byte};

    // Round function.
    always_comb begin
        unique case (r_round[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        w_g = r_block[word_index(r_round)];
        sum = r_a + f + round_const(r_round) + w_g;
        sh  = rot_amount(r_round);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // Padding byte for the current position: the marker, zero, or the length field.
    always_comb begin
        if (r_mark) begin
            pad_val = PAD_BYTE;
        end else if (!r_pad_twice && r_pad_pos >= LEN_START) begin
            pad_val = bits[{r_pad_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_val = '0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_item_take) begin
                    if (i_item.has_byte && pos == 6'd63) n_state = ST_ROUND;
                    else if (i_item.is_end) n_state = ST_PAD;
                end
            end
            ST_PAD:   if (r_pad_pos == 6'd63) n_state = ST_ROUND;
            ST_ROUND: if (r_round == 6'd63) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_pad_twice)  n_state = ST_PAD;
                else if (r_final) n_state = ST_OUT;
                else              n_state = ST_IDLE;
            end
            ST_OUT:  if (i_pop && r_word == 2'd3) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_empty = 1'b1;
        unique case (r_word)
            2'd0:    o_digest_word = r_ca;
            2'd1:    o_digest_word = r_cb;
            2'd2:    o_digest_word = r_cc;
            default: o_digest_word = r_cd;
        endcase
        o_word_number = r_word;
        o_last_word   = (r_word == 2'd3);
        if (r_state == ST_OUT) o_empty = 1'b0;
    end

    // Block buffer writes: message bytes, then the marker and fill while padding.
    always_ff @(posedge i_clk) begin
        if (take_byte_now) begin
            r_block[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= i_item.data;
        end else if (r_state == ST_PAD) begin
            r_block[r_pad_pos[5:2]][{r_pad_pos[1:0], 3'b000} +: 8] <= pad_val;
        end
    end

    // Control and chaining state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ca        <= INIT_A;
            r_cb        <= INIT_B;
            r_cc        <= INIT_C;
            r_cd        <= INIT_D;
            r_count     <= '0;
            r_round     <= '0;
            r_pad_pos   <= '0;
            r_final     <= 1'b0;
            r_pad_twice <= 1'b0;
            r_mark      <= 1'b0;
            r_word      <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_a <= r_ca; r_b <= r_cb; r_c <= r_cc; r_d <= r_cd;
                    r_round <= '0;
                    r_word  <= '0;
                    if (o_item_take) begin
                        r_final <= i_item.is_end;
                        r_mark  <= i_item.is_end;
                        if (i_item.has_byte) r_count <= r_count + 61'd1;
                        // A byte that fills the block leaves the marker
                        // for the start of a fresh block.
                        if (i_item.has_byte && pos == 6'd63) begin
                            r_pad_twice <= i_item.is_end;
                            r_pad_pos   <= '0;
                        end else begin
                            r_pad_twice <= (pad_start >= LEN_START);
                            r_pad_pos   <= pad_start;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_pos <= r_pad_pos + 6'd1;
                    r_mark    <= 1'b0;
                end
                ST_ROUND: begin
                    r_a <= r_d;
                    r_d <= r_c;
                    r_c <= r_b;
                    r_b <= r_b + rot;
                    r_round <= r_round + 6'd1;
                end
                ST_FOLD: begin
                    r_ca <= r_ca + r_a;
                    r_cb <= r_cb + r_b;
                    r_cc <= r_cc + r_c;
                    r_cd <= r_cd + r_d;
                    r_a <= r_ca + r_a; r_b <= r_cb + r_b;
                    r_c <= r_cc + r_c; r_d <= r_cd + r_d;
                    r_round <= '0;
                    if (r_pad_twice) begin
                        // The second block is padded from its first byte.
                        r_pad_twice <= 1'b0;
                        r_pad_pos   <= '0;
                    end
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_word <= r_word + 2'd1;
                        if (r_word == 2'd3) begin
                            r_ca <= INIT_A; r_cb <= INIT_B;
                            r_cc <= INIT_C; r_cd <= INIT_D;
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Streaming MD5 engine with a queue-style interface on both sides.
// ----------------------------------------------------------------------------
// Bytes are pushed one per item; an item with end_of_message set closes the
// message and yields the digest as four words, A first. A byte that does not
// fill a block is written into the block buffer; a byte that fills one starts
// a compression, with the single round unit doing one of the 64 rounds per
// cycle between load and fold. An end item pads the block one byte per cycle
// and compresses once or twice before the digest appears. A four-entry queue
// lets the producer keep pushing meanwhile.
module md5_message_digest import md5_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_number,
    output logic        o_last_word
);

    t_item item;
    logic  item_valid, item_take;

    // Front part: accept and queue.
    md5_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_item_take      (item_take)
    );

    // Back part: compress and deliver.
    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_take   (item_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest_word (o_digest_word),
        .o_word_number (o_word_number),
        .o_last_word   (o_last_word)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams messages of random length and content into the engine, with random
// gaps on both sides and one long output hold-off, and checks every digest
// word against a behavioural MD5 predictor kept in step with the input.
// ----------------------------------------------------------------------------
module tb import md5_pkg::*; ();

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  num;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        empty;
    logic        pop;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_number;
    logic        o_last_word;

    md5_message_digest dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_digest_word    (o_digest_word),
        .o_word_number    (o_word_number),
        .o_last_word      (o_last_word)
    );

    // Round tables for the predictor.
    logic [31:0] sine_tab [64];
    int unsigned shift_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    // Predictor state.
    logic [31:0] chain [4] = '{INIT_A, INIT_B, INIT_C, INIT_D};
    logic [7:0]  blk [64];
    logic [60:0] byte_cnt = '0;

    t_msg_item    pending_items [$];
    t_digest_word expected_words [$];
    int           errors = 0;
    bit           hold_req;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
        return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
    endfunction

    // One MD5 compression of blk into chain.
    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int unsigned g;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d); g = r;
            end else if (r < 32) begin
                f = (b & d) | (c & ~d); g = (5*r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d; g = (3*r + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7*r) % 16;
            end
            t = d; d = c; c = b;
            b = b + rotl(a + f + sine_tab[r] + w[g], shift_tab[(r/16)*4 + r%4]);
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic restart_digest();
        chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
        byte_cnt = '0;
    endtask

    // Advance the predictor by one accepted item and queue any digest words.
    task automatic predict_digest(t_msg_item it);
        logic [63:0] bit_len;
        int unsigned pos;
        if (it.has_byte) begin
            pos = byte_cnt[5:0];
            blk[pos] = it.data;
            byte_cnt = byte_cnt + 1'b1;
            if (pos == 63) compress();
        end
        if (it.is_end) begin
            bit_len = {byte_cnt, 3'b000};
            pos = byte_cnt[5:0];
            blk[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_START) begin
                while (pos < 64) blk[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < LEN_START) blk[pos++] = 8'h00;
            for (int k = 0; k < 8; k++) blk[56+k] = bit_len[8*k +: 8];
            compress();
            for (int k = 0; k < 4; k++)
                expected_words.push_back('{chain[k], 2'(k), k == 3});
            restart_digest();
        end
    endtask

    task automatic add_message(int unsigned len, bit end_with_byte, bit fixed_val,
                               logic [7:0] val);
        for (int unsigned i = 0; i < len; i++) begin
            logic [7:0] b;
            b = fixed_val ? val : 8'($urandom);
            if (end_with_byte && i == len - 1)
                pending_items.push_back('{b, 1'b1, 1'b1});
            else
                pending_items.push_back('{b, 1'b1, 1'b0});
            // Occasional idle items that the engine ignores.
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
        end
        if (!end_with_byte || len == 0)
            pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // Transfer on the input side is sampled at the rising edge; the driver acts on it
    // at the following falling edge, so a flag records it here.
    bit in_xfer;
    always @(posedge i_clk) in_xfer <= i_rst_n && push && !full;

    // Driver: offers the head of the queue with random gaps.
    int unsigned send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap <= 0;
            i_data_byte <= 8'h00;
            i_byte_present <= 1'b0;
            i_end_of_message <= 1'b0;
        end else begin
            if (in_xfer) begin
                predict_digest(pending_items.pop_front());
            end
            if (push && !in_xfer) begin
                // keep offering the same item
            end else if (send_gap > 0 || pending_items.size() == 0) begin
                push <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                push <= 1'b1;
                i_data_byte <= pending_items[0].data;
                i_byte_present <= pending_items[0].has_byte;
                i_end_of_message <= pending_items[0].is_end;
                if ($urandom_range(0, 2) == 0)
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                            : $urandom_range(1, 3);
            end
        end
    end

    // Monitor and receiver: checks each transfer, stalls at random.
    int unsigned recv_gap;
    int unsigned hold_count;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected digest word %h", $realtime, o_digest_word);
                errors++;
            end else begin
                t_digest_word e;
                e = expected_words.pop_front();
                if (o_digest_word !== e.word || o_word_number !== e.num
                        || o_last_word !== e.last)
                    $display("%0t: expected %h/%0d/%0b, actual %h/%0d/%0b", $realtime,
                             e.word, e.num, e.last, o_digest_word, o_word_number,
                             o_last_word);
                if (o_digest_word !== e.word || o_word_number !== e.num
                        || o_last_word !== e.last)
                    errors++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            recv_gap <= 0;
            hold_count <= 0;
        end else if (hold_req && hold_count < 3000) begin
            // Long hold-off so the engine fills and stalls its input.
            pop <= 1'b0;
            hold_count <= hold_count + 1;
        end else if (recv_gap > 0) begin
            pop <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(1, 3);
        end
    end

    // Stimulus.
    initial begin
        int unsigned total;
        sine_tab = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        hold_req = 0;
        i_rst_n = 1'b0;

        // Directed: empty message after reset, idle item, extremes of the byte,
        // byte with end, end alone, and back-to-back empty messages.
        pending_items.push_back('{8'hff, 1'b0, 1'b0});
        add_message(0, 0, 0, 8'h00);
        add_message(1, 1, 1, 8'h00);
        add_message(1, 0, 1, 8'hff);
        add_message(3, 1, 1, 8'haa);
        add_message(2, 0, 1, 8'h55);
        add_message(0, 0, 0, 8'h00);
        add_message(0, 0, 0, 8'h00);

        // Random messages; lengths chosen around the padding boundaries
        // (55, 56, 63, 64) and around 120 for longer multi-block messages.
        total = 0;
        while (total < 180) begin
            int unsigned len;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 65);
                3: len = $urandom_range(118, 121);
                default: len = $urandom_range(0, 70);
            endcase
            add_message(len, $urandom_range(0, 1), 0, 8'h00);
            total += len + 1;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hold the receiver off after reset while messages remain queued to fill the engine.
        repeat (200) @(posedge i_clk);
        hold_req = 1;

        wait (pending_items.size() == 0 && !push);
        wait (expected_words.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
